// ----- hw/rtl/pva_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants for the polyphonic voice allocator
// Operation codes, slot record layout, stream item layouts and sequencer states.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int PITCH_W = 7;
  localparam int TAG_W   = 32;
  localparam int CHAN_W  = 4;
  localparam int LEVEL_W = 16;

  localparam logic [PITCH_W-1:0] PITCH_IDLE = 7'd60;
  localparam logic [TAG_W-1:0]   TAG_NONE   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_NOTE_ON   = 2'd0,
    OP_NOTE_OFF  = 2'd1,
    OP_ALL_OFF   = 2'd2,
    OP_ENV_REPORT = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_PICK = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // one slot record in the voice memory
  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [TAG_W-1:0]   tag;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] amplitude;
    logic [LEVEL_W-1:0] level;
  } rec_t;

  // input item payload, lowest field last
  typedef struct packed {
    logic               pad;
    logic               env_running;
    logic [LEVEL_W-1:0] env_level;
    logic [2:0]         report_slot;
    logic [LEVEL_W-1:0] velocity;
    logic [CHAN_W-1:0]  channel;
    logic [TAG_W-1:0]   note_tag;
    logic [PITCH_W-1:0] pitch;
  } in_item_t;

  // result item payload, lowest field last
  typedef struct packed {
    logic [1:0] pad;
    logic [3:0] active_count;
    logic       freed;
    logic [3:0] released_count;
    logic       stole_active;
    logic       slot_valid;
    logic [2:0] slot;
  } out_item_t;

  function automatic logic [3:0] sat4(input logic [5:0] v);
    logic [3:0] r;
    r = (v > 6'd15) ? 4'hF : v[3:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pva_pick.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pva_pick: note_on slot selection
// Watches slot records as the scan streams them and keeps the first direct
// hit, the quietest released slot and the quietest slot overall.
// ----------------------------------------------------------------------------
module pva_pick #(
  parameter int VOICES = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          clear,
  input  wire                          obs_valid,
  input  wire [$clog2(VOICES)-1:0]     obs_idx,
  input  wire                          obs_cand,
  input  wire                          obs_held,
  input  wire [pva_pkg::LEVEL_W-1:0]   obs_level,
  output logic [$clog2(VOICES)-1:0]    pick_idx
);

  localparam int IW = $clog2(VOICES);

  logic                        hit;
  logic [IW-1:0]               hit_idx;
  logic                        rel_found;
  logic [IW-1:0]               rel_idx;
  logic [pva_pkg::LEVEL_W-1:0] rel_lvl;
  logic [IW-1:0]               quiet_idx;
  logic [pva_pkg::LEVEL_W-1:0] quiet_lvl;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hit       <= 1'b0;
      rel_found <= 1'b0;
    end else if (obs_valid && !hit) begin
      if (obs_cand) begin
        hit     <= 1'b1;
        hit_idx <= obs_idx;
      end else begin
        if (!obs_held && (!rel_found || obs_level < rel_lvl)) begin
          rel_found <= 1'b1;
          rel_idx   <= obs_idx;
          rel_lvl   <= obs_level;
        end
        // strict compare keeps the lowest slot on equal levels
        if (obs_idx == '0 || obs_level < quiet_lvl) begin
          quiet_idx <= obs_idx;
          quiet_lvl <= obs_level;
        end
      end
    end
  end

  assign pick_idx = hit ? hit_idx : (rel_found ? rel_idx : quiet_idx);

endmodule
`default_nettype wire

// ----- hw/rtl/poly_voice_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// poly_voice_allocator: polyphonic voice allocator with voice stealing
// Slot records live in a one-port-read, one-port-write memory; active and
// held flags are flops. Each item walks the memory and writes back changes.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tuser: operation; tdata: pitch .. env_running
// m_axis    out  tdata: slot, slot_valid, stole_active, released_count,
//                freed, active_count
//
// note_on runs scan, pick and done; note_off and all_notes_off run scan and
// done; an envelope report scans only its slot, an ignored one goes straight
// to done. The scan reads one slot record per cycle from the memory port.
// One item is in work at a time; s_tready is high only in idle.
// A finished result sits in the output register; the next item is taken
// while it waits, and its own result waits until the register is free.
// Reset clears all flags at once; the record memory needs no clearing.
// ----------------------------------------------------------------------------
module poly_voice_allocator #(
  parameter int VOICES = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // [6:0] pitch, [38:7] note_tag, [42:39] channel, [58:43] velocity,
  // [61:59] report_slot, [77:62] env_level, [78] env_running, [79] zero
  input  wire  [79:0] s_tdata,
  // [1:0] operation
  input  wire  [1:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // [2:0] slot, [3] slot_valid, [4] stole_active, [8:5] released_count,
  // [9] freed, [13:10] active_count, [15:14] zero
  output logic [15:0] m_tdata
);

  localparam int IW = $clog2(VOICES);
  localparam int CW = $clog2(VOICES + 1);

  pva_pkg::state_t   state;
  pva_pkg::op_t      op;
  pva_pkg::in_item_t in_item;
  pva_pkg::in_item_t q;

  logic [VOICES-1:0] active;
  logic [VOICES-1:0] held;
  logic [CW-1:0]     act_cnt;
  logic [CW-1:0]     rel_cnt;

  logic [IW-1:0] issue_idx;
  logic [IW-1:0] last_idx;
  logic          issuing;
  logic          dv;
  logic [IW-1:0] dv_idx;
  logic          dv_last;

  logic       w_valid;
  logic       w_stole;
  logic       w_freed;
  logic [2:0] w_slot;

  pva_pkg::rec_t mem [VOICES];
  pva_pkg::rec_t rd_data;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  pva_pkg::rec_t wr_rec;

  logic          accept;
  logic [IW-1:0] ridx;
  logic          rep_ok;
  logic          tag_eq;
  logic          chan_eq;
  logic          pitch_eq;
  logic          on_cand;
  logic          off_match;
  logic          rel_hit;
  logic          free_hit;
  logic          obs_valid;
  logic [IW-1:0] pick_idx;
  pva_pkg::out_item_t res;

  assign in_item  = pva_pkg::in_item_t'(s_tdata);
  assign s_tready = (state == pva_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign ridx   = IW'(in_item.report_slot);
  assign rep_ok = (32'(in_item.report_slot) < 32'(VOICES)) && active[ridx];

  // record compare against the held item
  assign tag_eq   = !rd_data.tag[31] && !q.note_tag[31] && (rd_data.tag == q.note_tag);
  assign chan_eq  = (rd_data.channel == q.channel);
  assign pitch_eq = (rd_data.pitch == q.pitch);
  assign on_cand  = !active[dv_idx] || (tag_eq && chan_eq) || (pitch_eq && chan_eq);
  assign off_match = tag_eq || (pitch_eq && chan_eq);

  always_comb begin
    rel_hit  = 1'b0;
    free_hit = 1'b0;
    if (state == pva_pkg::ST_SCAN && dv) begin
      unique case (op)
        pva_pkg::OP_NOTE_ON:    rel_hit = 1'b0;
        pva_pkg::OP_NOTE_OFF:   rel_hit = active[dv_idx] && off_match;
        pva_pkg::OP_ALL_OFF:    rel_hit = active[dv_idx];
        pva_pkg::OP_ENV_REPORT: free_hit = !held[dv_idx] && !q.env_running &&
                                           (q.env_level == '0);
        default:                rel_hit = 1'b0;
      endcase
    end
  end

  assign obs_valid = (state == pva_pkg::ST_SCAN) && dv && (op == pva_pkg::OP_NOTE_ON);

  pva_pick #(.VOICES(VOICES)) u_pick (
    .clk       (clk),
    .rst       (rst),
    .clear     (accept),
    .obs_valid (obs_valid),
    .obs_idx   (dv_idx),
    .obs_cand  (on_cand),
    .obs_held  (held[dv_idx]),
    .obs_level (rd_data.level),
    .pick_idx  (pick_idx)
  );

  // write-back port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dv_idx;
    wr_rec  = rd_data;
    if (state == pva_pkg::ST_PICK) begin
      wr_en            = 1'b1;
      wr_addr          = pick_idx;
      wr_rec.pitch     = q.pitch;
      wr_rec.tag       = q.note_tag;
      wr_rec.channel   = q.channel;
      wr_rec.amplitude = q.velocity;
      wr_rec.level     = '0;
    end else if (rel_hit) begin
      wr_en      = 1'b1;
      wr_rec.tag = pva_pkg::TAG_NONE;
    end else if (state == pva_pkg::ST_SCAN && dv && op == pva_pkg::OP_ENV_REPORT) begin
      wr_en        = 1'b1;
      wr_rec.level = q.env_level;
      if (free_hit) begin
        wr_rec.pitch     = pva_pkg::PITCH_IDLE;
        wr_rec.channel   = '0;
        wr_rec.amplitude = '0;
      end
    end
  end

  assign rd_en = (state == pva_pkg::ST_SCAN) && issuing;

  // reads and writes of one item never touch the same entry in one cycle;
  // items are sequenced, so no forwarding path is needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_data <= mem[issue_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pva_pkg::ST_IDLE;
      active   <= '0;
      held     <= '0;
      act_cnt  <= '0;
      issuing  <= 1'b0;
      dv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // in done the output register is reloaded below
      if (m_tvalid && m_tready && state != pva_pkg::ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        pva_pkg::ST_IDLE: begin
          if (accept) begin
            q       <= in_item;
            op      <= pva_pkg::op_t'(s_tuser);
            rel_cnt <= '0;
            w_valid <= 1'b0;
            w_stole <= 1'b0;
            w_freed <= 1'b0;
            w_slot  <= '0;
            dv      <= 1'b0;
            if (pva_pkg::op_t'(s_tuser) == pva_pkg::OP_ENV_REPORT) begin
              w_slot    <= in_item.report_slot;
              issue_idx <= ridx;
              last_idx  <= ridx;
              issuing   <= rep_ok;
              w_valid   <= rep_ok;
              state     <= rep_ok ? pva_pkg::ST_SCAN : pva_pkg::ST_DONE;
            end else begin
              issue_idx <= '0;
              last_idx  <= IW'(VOICES - 1);
              issuing   <= 1'b1;
              state     <= pva_pkg::ST_SCAN;
            end
          end
        end
        pva_pkg::ST_SCAN: begin
          dv <= issuing;
          if (issuing) begin
            dv_idx  <= issue_idx;
            dv_last <= (issue_idx == last_idx);
            if (issue_idx == last_idx) begin
              issuing <= 1'b0;
            end else begin
              issue_idx <= issue_idx + IW'(1);
            end
          end
          if (rel_hit) begin
            held[dv_idx] <= 1'b0;
            rel_cnt      <= rel_cnt + CW'(held[dv_idx]);
          end
          if (free_hit) begin
            active[dv_idx] <= 1'b0;
            act_cnt        <= act_cnt - CW'(1);
            w_freed        <= 1'b1;
          end
          if (dv && dv_last) begin
            state <= (op == pva_pkg::OP_NOTE_ON) ? pva_pkg::ST_PICK : pva_pkg::ST_DONE;
          end
        end
        pva_pkg::ST_PICK: begin
          active[pick_idx] <= 1'b1;
          held[pick_idx]   <= 1'b1;
          if (!active[pick_idx]) begin
            act_cnt <= act_cnt + CW'(1);
          end
          w_stole <= active[pick_idx];
          w_valid <= 1'b1;
          w_slot  <= 3'(pick_idx);
          state   <= pva_pkg::ST_DONE;
        end
        pva_pkg::ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            state    <= pva_pkg::ST_IDLE;
          end
        end
        default: state <= pva_pkg::ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res                = '0;
    res.slot           = w_slot;
    res.slot_valid     = w_valid;
    res.stole_active   = w_stole;
    res.released_count = pva_pkg::sat4(6'(rel_cnt));
    res.freed          = w_freed;
    res.active_count   = pva_pkg::sat4(6'(act_cnt));
  end

  // ---- assertions ----
  a_cnt_tracks_flags: assert property (@(posedge clk) disable iff (rst)
    32'(act_cnt) == $countones(active))
    else $error("active counter out of step with active flags");

  a_held_implies_active: assert property (@(posedge clk) disable iff (rst)
    (held & ~active) == '0)
    else $error("held slot that is not active");

  a_freed_has_slot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9]) |-> m_tdata[3])
    else $error("freed result without a valid slot");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == pva_pkg::ST_SCAN) |=> !$past(s_tready))
    else $error("input accepted during a scan");

endmodule
`default_nettype wire
